// ===== hdl/contiguous_page_allocator_macros.svh =====
// ----------------------------------------------------------------------------
// Contiguous page allocator assertion macros
// Shared concurrent assertion forms, clocked on clock and disabled in reset.
// ----------------------------------------------------------------------------
`ifndef CONTIGUOUS_PAGE_ALLOCATOR_MACROS_SVH
`define CONTIGUOUS_PAGE_ALLOCATOR_MACROS_SVH

// Consequent must hold in the same cycle as the antecedent.
`define CPA_ASSERT_SAME(label, ante, cons, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error(msg);

// Consequent must hold in the cycle after the antecedent.
`define CPA_ASSERT_NEXT(label, ante, cons, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error(msg);

`endif

// ===== hdl/cpa_pkg.sv =====
// ----------------------------------------------------------------------------
// Contiguous page allocator package
// Beat types, command and status codes, sequencer states and control structs.
// ----------------------------------------------------------------------------
package cpa_pkg;

   // Default size of the page table.
   localparam int PAGES_DEFAULT = 16;

   // Command codes.
   localparam logic CMD_ALLOC = 1'b0;
   localparam logic CMD_FREE  = 1'b1;

   // Result status codes.
   localparam logic [1:0] STATUS_DONE = 2'd0;
   localparam logic [1:0] STATUS_BAD  = 2'd1;
   localparam logic [1:0] STATUS_FULL = 2'd2;

   // Request beat.
   typedef struct packed {
      logic       cmd;
      logic [3:0] first_page;
      logic [4:0] page_count;
   } req_type;

   // Result beat.
   typedef struct packed {
      logic [1:0] status;
      logic [3:0] granted_start;
      logic [4:0] already_free;
      logic [4:0] used_total;
   } rsp_type;

   // Sequencer states.
   typedef enum logic [2:0] {
      ST_IDLE,
      ST_SCAN,
      ST_MARK,
      ST_CLEAR,
      ST_RESP
   } state_type;

   // Step strobes from the sequencer to the page unit.
   typedef struct packed {
      logic load;
      logic scan;
      logic mark;
      logic clear;
   } ctrl_type;

   // Conditions from the page unit to the sequencer.
   typedef struct packed {
      logic req_bad;
      logic req_free;
      logic scan_hit;
      logic scan_end;
      logic last_beat;
   } cond_type;

endpackage

// ===== hdl/contiguous_page_allocator.sv =====
// ----------------------------------------------------------------------------
// Contiguous page allocator
// First-fit allocator over a bitmap of PAGES pages, one page handled a cycle.
// ----------------------------------------------------------------------------
// Usage:
// A request beat (req_data) is taken at a rising edge where start is high and
// busy is low. An allocate scans the map from page 0 one page per cycle until
// it finds page_count free pages in a row, then marks that run, one page per
// cycle. A free walks its range one page per cycle, clearing marks and counting
// pages that were free already. Every request gives exactly one result beat on
// rsp_data, marked by rsp_strobe for one cycle; the receiver cannot stall it.
// An allocate that finds a run goes from the scan pass to the mark pass and
// then to the result; one that finds none ends the scan at the last page with
// status full. A free goes from its clear pass to the result, and an invalid
// request goes straight to the result. The next request is taken the cycle
// after the strobe, so a request occupies the block until its result beat is
// done. Reset is synchronous; it marks all pages free and returns the block to
// idle with no result pending.
// ----------------------------------------------------------------------------
module contiguous_page_allocator #(
   parameter int PAGES = cpa_pkg::PAGES_DEFAULT
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             start,
   input  cpa_pkg::req_type req_data,
   output logic             busy,
   output logic             rsp_strobe,
   output cpa_pkg::rsp_type rsp_data
);

   cpa_pkg::ctrl_type ctrl;
   cpa_pkg::cond_type cond;

   // Sequencer.
   cpa_seq u_seq (
      .clock      (clock),
      .reset      (reset),
      .start      (start),
      .cond       (cond),
      .ctrl       (ctrl),
      .busy       (busy),
      .rsp_strobe (rsp_strobe)
   );

   // Page map and step unit.
   cpa_unit #(
      .PAGES (PAGES)
   ) u_unit (
      .clock    (clock),
      .reset    (reset),
      .req_data (req_data),
      .ctrl     (ctrl),
      .cond     (cond),
      .rsp_data (rsp_data)
   );

endmodule

// ===== hdl/cpa_seq.sv =====
// ----------------------------------------------------------------------------
// Contiguous page allocator sequencer
// Steps the page unit through scan, mark and clear passes, one page a cycle.
// ----------------------------------------------------------------------------
`include "contiguous_page_allocator_macros.svh"

module cpa_seq (
   input  logic              clock,
   input  logic              reset,
   input  logic              start,
   input  cpa_pkg::cond_type cond,
   output cpa_pkg::ctrl_type ctrl,
   output logic              busy,
   output logic              rsp_strobe
);

   cpa_pkg::state_type state_ff;
   cpa_pkg::state_type state_in;

   // Next state.
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         cpa_pkg::ST_IDLE: begin
            if (start) begin
               if (cond.req_bad) begin
                  state_in = cpa_pkg::ST_RESP;
               end else if (cond.req_free) begin
                  state_in = cpa_pkg::ST_CLEAR;
               end else begin
                  state_in = cpa_pkg::ST_SCAN;
               end
            end
         end
         cpa_pkg::ST_SCAN: begin
            if (cond.scan_hit) begin
               state_in = cpa_pkg::ST_MARK;
            end else if (cond.scan_end) begin
               state_in = cpa_pkg::ST_RESP;
            end
         end
         cpa_pkg::ST_MARK: begin
            if (cond.last_beat) begin
               state_in = cpa_pkg::ST_RESP;
            end
         end
         cpa_pkg::ST_CLEAR: begin
            if (cond.last_beat) begin
               state_in = cpa_pkg::ST_RESP;
            end
         end
         cpa_pkg::ST_RESP: begin
            state_in = cpa_pkg::ST_IDLE;
         end
         default: begin
            state_in = cpa_pkg::ST_IDLE;
         end
      endcase
   end

   // Outputs decoded from the state.
   always_comb begin
      ctrl.load  = (state_ff == cpa_pkg::ST_IDLE) && start;
      ctrl.scan  = (state_ff == cpa_pkg::ST_SCAN);
      ctrl.mark  = (state_ff == cpa_pkg::ST_MARK);
      ctrl.clear = (state_ff == cpa_pkg::ST_CLEAR);
      busy       = (state_ff != cpa_pkg::ST_IDLE);
      rsp_strobe = (state_ff == cpa_pkg::ST_RESP);
   end

   // State register.
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= cpa_pkg::ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   // A result beat lasts one cycle, an accepted request makes the block busy, and no request is loaded while busy.
   `CPA_ASSERT_NEXT(a_strobe_single, rsp_strobe, !rsp_strobe, "result strobe held over two cycles")
   `CPA_ASSERT_NEXT(a_accept_busy, start && !busy, busy, "accepted request did not raise busy")
   `CPA_ASSERT_SAME(a_steps_exclusive, busy, !ctrl.load, "request loaded while busy")

endmodule

// ===== hdl/cpa_unit.sv =====
// ----------------------------------------------------------------------------
// Contiguous page allocator page unit
// Holds the used map and counters; examines or updates one page per step.
// ----------------------------------------------------------------------------
`include "contiguous_page_allocator_macros.svh"

module cpa_unit #(
   parameter int PAGES = cpa_pkg::PAGES_DEFAULT
) (
   input  logic              clock,
   input  logic              reset,
   input  cpa_pkg::req_type  req_data,
   input  cpa_pkg::ctrl_type ctrl,
   output cpa_pkg::cond_type cond,
   output cpa_pkg::rsp_type  rsp_data
);

   localparam int PTR_W = $clog2(PAGES);
   localparam int CNT_W = $clog2(PAGES + 1);
   localparam int CMP_W = ((CNT_W > 5) ? CNT_W : 5) + 1;

   logic [PAGES-1:0] map_ff,     map_in;
   logic [PTR_W-1:0] ptr_ff,     ptr_in;
   logic [CNT_W-1:0] run_ff,     run_in;
   logic [CNT_W-1:0] rem_ff,     rem_in;
   logic [CNT_W-1:0] used_ff,    used_in;
   logic [CNT_W-1:0] already_ff, already_in;
   logic [1:0]       status_ff,  status_in;
   logic [3:0]       granted_ff, granted_in;

   logic [CMP_W-1:0] req_count;
   logic [CMP_W-1:0] req_first;
   logic             page_used;
   logic [PTR_W-1:0] run_start;

   // Request checks on the incoming beat, and scan conditions for the page
   // under the pointer.
   always_comb begin
      req_count = CMP_W'(req_data.page_count);
      req_first = CMP_W'(req_data.first_page);
      cond.req_free = (req_data.cmd == cpa_pkg::CMD_FREE);
      if (cond.req_free) begin
         cond.req_bad = (req_count == '0) || (req_first >= CMP_W'(PAGES)) ||
                        ((req_first + req_count) > CMP_W'(PAGES));
      end else begin
         cond.req_bad = (req_count == '0) || (req_count > CMP_W'(PAGES));
      end
      page_used      = map_ff[ptr_ff];
      cond.scan_hit  = !page_used && (CNT_W'(run_ff + CNT_W'(1)) == rem_ff);
      cond.scan_end  = (ptr_ff == PTR_W'(PAGES - 1));
      cond.last_beat = (rem_ff == CNT_W'(1));
      run_start      = ptr_ff - PTR_W'(rem_ff - CNT_W'(1));
   end

   // Shared step logic: one page examined or updated per cycle.
   always_comb begin
      map_in     = map_ff;
      ptr_in     = ptr_ff;
      run_in     = run_ff;
      rem_in     = rem_ff;
      used_in    = used_ff;
      already_in = already_ff;
      status_in  = status_ff;
      granted_in = granted_ff;
      priority if (ctrl.load) begin
         ptr_in     = cond.req_free ? PTR_W'(req_data.first_page) : '0;
         run_in     = '0;
         rem_in     = CNT_W'(req_data.page_count);
         already_in = '0;
         granted_in = '0;
         status_in  = cond.req_bad ? cpa_pkg::STATUS_BAD : cpa_pkg::STATUS_DONE;
      end else if (ctrl.scan) begin
         run_in = page_used ? '0 : CNT_W'(run_ff + CNT_W'(1));
         if (cond.scan_hit) begin
            ptr_in     = run_start;
            granted_in = 4'(run_start);
         end else if (cond.scan_end) begin
            status_in = cpa_pkg::STATUS_FULL;
         end else begin
            ptr_in = ptr_ff + PTR_W'(1);
         end
      end else if (ctrl.mark) begin
         map_in[ptr_ff] = 1'b1;
         used_in        = used_ff + CNT_W'(1);
         ptr_in         = ptr_ff + PTR_W'(1);
         rem_in         = rem_ff - CNT_W'(1);
      end else if (ctrl.clear) begin
         map_in[ptr_ff] = 1'b0;
         if (page_used) begin
            used_in = used_ff - CNT_W'(1);
         end else begin
            already_in = already_ff + CNT_W'(1);
         end
         ptr_in = ptr_ff + PTR_W'(1);
         rem_in = rem_ff - CNT_W'(1);
      end
   end

   // Map and used count are cleared by reset; the rest is working data.
   always_ff @(posedge clock) begin
      if (reset) begin
         map_ff  <= '0;
         used_ff <= '0;
      end else begin
         map_ff  <= map_in;
         used_ff <= used_in;
      end
   end

   always_ff @(posedge clock) begin
      ptr_ff     <= ptr_in;
      run_ff     <= run_in;
      rem_ff     <= rem_in;
      already_ff <= already_in;
      status_ff  <= status_in;
      granted_ff <= granted_in;
   end

   // Result beat, counts masked to the field widths.
   always_comb begin
      rsp_data.status        = status_ff;
      rsp_data.granted_start = granted_ff;
      rsp_data.already_free  = 5'(already_ff);
      rsp_data.used_total    = 5'(used_ff);
   end

   // The used count tracks the map, a mark pass only ever takes free pages, and a clear pass leaves its page free.
   `CPA_ASSERT_SAME(a_used_count, 1'b1, CNT_W'($countones(map_ff)) == used_ff, "used count off")
   `CPA_ASSERT_SAME(a_mark_free_page, ctrl.mark, !map_ff[ptr_ff], "mark pass hit a used page")
   `CPA_ASSERT_NEXT(a_clear_takes, ctrl.clear, !map_ff[$past(ptr_ff)], "cleared page still used")

endmodule
